// ===== src/bol_pkg.sv =====
// Shared types and codes for the bounded ordered list unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package bol_pkg;

  // Requested operation.
  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_REM_FRONT = 2'd1,
    OP_REM_TAIL  = 2'd2,
    OP_REM_MATCH = 2'd3
  } op_e;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_TAIL  = 2'd1,
    S_SCAN  = 2'd2,
    S_SHIFT = 2'd3
  } state_e;

  // Memory read address selection.
  typedef enum logic [1:0] {
    RD_TAIL  = 2'd0,
    RD_ZERO  = 2'd1,
    RD_NEXT  = 2'd2,
    RD_NEXT2 = 2'd3
  } rd_sel_e;

  // Walk index update.
  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_e;

  // Source of the removed value in a result beat.
  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_RD    = 2'd1,
    RES_SAVED = 2'd2
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_e  rd_sel;
    idx_op_e  idx_op;
    logic     wr_append;
    logic     wr_shift;
    logic     cap_saved;
    logic     used_inc;
    logic     used_dec;
    logic     resp;
    status_e  resp_status;
    res_sel_e res_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

// ===== src/bol_datapath.sv =====
// Datapath of the bounded ordered list unit: element memory, count, walk index
// and result registers. Depends on bol_pkg for the command and status structs.
`timescale 1ns / 1ps

module bol_datapath #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bol_pkg::dp_cmd_t   cmd_i,
  input  logic [31:0]        value_i,
  output bol_pkg::dp_stat_t  stat_o,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic [31:0]        removed_value_o,
  output logic [CW-1:0]      count_o
);

  logic [31:0]      mem_q [DEPTH];
  logic [31:0]      rd_q;
  logic [31:0]      val_q;
  logic [31:0]      saved_q;
  logic [AW-1:0]    idx_q;
  logic [AW-1:0]    idx_d;
  logic [CW-1:0]    used_q;
  logic [CW-1:0]    used_d;
  logic [CW-1:0]    idx_next;
  logic [AW-1:0]    rd_addr;
  logic             valid_q;
  bol_pkg::status_e status_q;
  logic [31:0]      removed_q;
  logic [CW-1:0]    count_q;

  // Position after the current one, wide enough to compare with the count.
  assign idx_next = CW'(idx_q) + CW'(1);

  // Read address for the next beat of memory data.
  always_comb begin
    unique case (cmd_i.rd_sel)
      bol_pkg::RD_TAIL:  rd_addr = AW'(used_q - CW'(1));
      bol_pkg::RD_ZERO:  rd_addr = '0;
      bol_pkg::RD_NEXT:  rd_addr = idx_q + AW'(1);
      bol_pkg::RD_NEXT2: rd_addr = idx_q + AW'(2);
      default:           rd_addr = '0;
    endcase
  end

  // Element memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_append) begin
      mem_q[AW'(used_q)] <= value_i;
    end else if (cmd_i.wr_shift) begin
      mem_q[idx_q] <= rd_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Search key and the value found for removal.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
    end
    if (cmd_i.cap_saved) begin
      saved_q <= rd_q;
    end
  end

  // Walk index and element count.
  always_comb begin
    unique case (cmd_i.idx_op)
      bol_pkg::IDX_CLR: idx_d = '0;
      bol_pkg::IDX_INC: idx_d = idx_q + AW'(1);
      default:          idx_d = idx_q;
    endcase
    used_d = used_q;
    if (cmd_i.used_inc) begin
      used_d = used_q + CW'(1);
    end else if (cmd_i.used_dec) begin
      used_d = used_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      used_q <= '0;
    end else begin
      idx_q  <= idx_d;
      used_q <= used_d;
    end
  end

  // Result registers; the strobe is control, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      status_q <= cmd_i.resp_status;
      count_q  <= used_d;
      case (cmd_i.res_sel)
        bol_pkg::RES_RD:    removed_q <= rd_q;
        bol_pkg::RES_SAVED: removed_q <= saved_q;
        default:            removed_q <= '0;
      endcase
    end
  end

  // Status towards the controller.
  assign stat_o.full  = (used_q == CW'(DEPTH));
  assign stat_o.empty = (used_q == '0);
  assign stat_o.match = (rd_q == val_q);
  assign stat_o.last  = (idx_next == used_q);

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;

endmodule

// ===== src/bol_ctrl.sv =====
// Controller of the bounded ordered list unit: sequences appends, tail reads,
// the search walk and the gap-closing shift. Depends on bol_pkg.
`timescale 1ns / 1ps

module bol_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        operation_i,
  input  bol_pkg::dp_stat_t stat_i,
  output logic              busy,
  output bol_pkg::dp_cmd_t  cmd_o
);

  bol_pkg::state_e state_q;
  bol_pkg::state_e state_d;
  bol_pkg::op_e    op_q;
  bol_pkg::op_e    op_in;
  logic            accept;
  logic            hit;

  assign op_in  = bol_pkg::op_e'(operation_i);
  assign accept = start && (state_q == bol_pkg::S_IDLE);
  // The front removal takes the first element it sees.
  assign hit    = (op_q == bol_pkg::OP_REM_FRONT) || stat_i.match;

  // State and latched operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bol_pkg::S_IDLE;
      op_q    <= bol_pkg::OP_APPEND;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= op_in;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bol_pkg::S_IDLE: begin
        if (accept && (op_in != bol_pkg::OP_APPEND) && !stat_i.empty) begin
          if (op_in == bol_pkg::OP_REM_TAIL) begin
            state_d = bol_pkg::S_TAIL;
          end else begin
            state_d = bol_pkg::S_SCAN;
          end
        end
      end
      bol_pkg::S_TAIL: begin
        state_d = bol_pkg::S_IDLE;
      end
      bol_pkg::S_SCAN: begin
        if (hit) begin
          state_d = bol_pkg::S_SHIFT;
        end else if (stat_i.last) begin
          state_d = bol_pkg::S_IDLE;
        end
      end
      bol_pkg::S_SHIFT: begin
        if (stat_i.last) begin
          state_d = bol_pkg::S_IDLE;
        end
      end
      default: state_d = bol_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o             = '0;
    cmd_o.rd_sel      = bol_pkg::RD_ZERO;
    cmd_o.idx_op      = bol_pkg::IDX_HOLD;
    cmd_o.resp_status = bol_pkg::ST_OK;
    cmd_o.res_sel     = bol_pkg::RES_ZERO;
    cmd_o.load        = accept;
    unique case (state_q)
      bol_pkg::S_IDLE: begin
        if (accept) begin
          if (op_in == bol_pkg::OP_APPEND) begin
            cmd_o.resp = 1'b1;
            if (stat_i.full) begin
              cmd_o.resp_status = bol_pkg::ST_FULL;
            end else begin
              cmd_o.wr_append = 1'b1;
              cmd_o.used_inc  = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.resp        = 1'b1;
            cmd_o.resp_status = bol_pkg::ST_EMPTY;
          end else if (op_in == bol_pkg::OP_REM_TAIL) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = bol_pkg::RD_TAIL;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = bol_pkg::RD_ZERO;
            cmd_o.idx_op = bol_pkg::IDX_CLR;
          end
        end
      end
      bol_pkg::S_TAIL: begin
        cmd_o.used_dec = 1'b1;
        cmd_o.resp     = 1'b1;
        cmd_o.res_sel  = bol_pkg::RES_RD;
      end
      bol_pkg::S_SCAN: begin
        if (hit) begin
          cmd_o.cap_saved = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = bol_pkg::RD_NEXT;
        end else if (stat_i.last) begin
          cmd_o.resp        = 1'b1;
          cmd_o.resp_status = bol_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bol_pkg::RD_NEXT;
          cmd_o.idx_op = bol_pkg::IDX_INC;
        end
      end
      bol_pkg::S_SHIFT: begin
        if (stat_i.last) begin
          cmd_o.used_dec = 1'b1;
          cmd_o.resp     = 1'b1;
          cmd_o.res_sel  = bol_pkg::RES_SAVED;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.idx_op   = bol_pkg::IDX_INC;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = bol_pkg::RD_NEXT2;
        end
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  assign busy = (state_q != bol_pkg::S_IDLE);

endmodule

// ===== src/bounded_ordered_list_unit.sv =====
// Bounded ordered list unit. An append or any refused request is answered
// without leaving idle; a tail removal first reads the tail entry; a search
// walks the entries from the front, one entry a cycle, and stops at the last on
// a miss; a front or by-value removal then shifts the later entries over the gap.
// busy is low again in the cycle of the result beat; the receiver cannot stall.
// Reset empties the list at once; element contents stay undefined until written.
`timescale 1ns / 1ps

module bounded_ordered_list_unit #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    operation_i,
  input  logic [31:0]   value_i,
  output logic          valid_o,
  output logic [1:0]    status_o,
  output logic [31:0]   removed_value_o,
  output logic [CW-1:0] count_o
);

  bol_pkg::dp_cmd_t  cmd;
  bol_pkg::dp_stat_t stat;

  // Sequencer.
  bol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // Storage and result registers.
  bol_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .stat_o          (stat),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o)
  );

  // Every result beat is issued as the controller returns to idle.
  a_valid_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat while busy");

  // The count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (count_o <= CW'(DEPTH)))
    else $error("count beyond capacity");

  // A refused append is only reported on a full list.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == bol_pkg::ST_FULL)) |-> (count_o == CW'(DEPTH)))
    else $error("full status with spare room");

  // An empty report carries a zero count and no removed value.
  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == bol_pkg::ST_EMPTY)) |->
      ((count_o == '0) && (removed_value_o == '0)))
    else $error("empty status on a non-empty list");

  // An accepted append leaves the unit free, with its result beat, in the next cycle.
  a_append_quick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == bol_pkg::OP_APPEND)) |=> (valid_o && !busy))
    else $error("append did not complete in one cycle");

endmodule
